@@ hdl/btsu_pkg.sv @@
// Shared constants, request codes and a helper for the bitmap task scheduler.
`default_nettype none
package btsu_pkg;
  localparam int MAX_TASKS       = 32;
  localparam int GUARDS_PER_TASK = 8;
  localparam int NUM_WAIT_LISTS  = 16;
  localparam int NUM_GUARD_WORDS = 16;

  localparam int TASK_W = $clog2(MAX_TASKS);
  localparam int GI_W   = $clog2(GUARDS_PER_TASK);
  localparam int GCNT_W = $clog2(GUARDS_PER_TASK + 1);
  localparam int LIST_W = 4;
  localparam int GID_W  = 4;
  localparam int TIME_W = 32;

  typedef enum logic [3:0] {
    REQ_CREATE    = 4'd0,
    REQ_SELECT    = 4'd1,
    REQ_TERMINATE = 4'd2,
    REQ_BLK_LIST  = 4'd3,
    REQ_BLK_DL    = 4'd4,
    REQ_BLK_BOTH  = 4'd5,
    REQ_SIGNAL    = 4'd6,
    REQ_TICK      = 4'd7,
    REQ_REG_GUARD = 4'd8,
    REQ_GUARD_DL  = 4'd9,
    REQ_WAIT      = 4'd10,
    REQ_ACCEPT    = 4'd11,
    REQ_GCHANGED  = 4'd12,
    REQ_GTICK     = 4'd13
  } req_t;

  localparam logic [1:0] GS_EVAL    = 2'd0;
  localparam logic [1:0] GS_CHANGED = 2'd1;
  localparam logic [1:0] GS_WAITING = 2'd2;

  // index of the lowest set bit, 0 when none
  function automatic logic [TASK_W-1:0] low_bit(input logic [MAX_TASKS-1:0] v);
    logic [TASK_W-1:0] idx;
    idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (v[i]) idx = TASK_W'(i);
    end
    return idx;
  endfunction
endpackage
`default_nettype wire

@@ hdl/bitmap_task_scheduler_unit.sv @@
// Top level of the bitmap task scheduler: request sequencer and state.
`default_nettype none
// Each input transaction is one scheduler request; exactly one result transaction
// follows it. The block handles one request at a time. Create, select, terminate,
// block, signal, register guard, wait and unused codes go from the execute state
// straight to the result state; guard deadline, for a task in the evaluating
// state, adds a deadline check state. The deadline tick walks all 32 task
// deadlines held in a one-port-read RAM (address, then compare, per task). Guard
// tick walks the same way and, for each task that fires, clears that task's
// guards from the guard words through the guard-id RAM, one guard at a time.
// Guard changed does the same per-task clearing for each member of the guard word,
// and accept guard does it for the running task. The result sits in an output
// register, so a new request is taken as soon as the sequencer is back in idle.
module bitmap_task_scheduler_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] req_type, [8:4] task_index, [12:9] list_id, [16:13] guard_id,
  // [48:17] time_value, [55:49] zero
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] running_valid, [5:1] running_task, [6] running_return_code, [7] flag,
  // [8] error, [40:9] ready_mask, [47:41] zero
  output logic      [47:0] out_tdata
);
  localparam int NT = btsu_pkg::MAX_TASKS;
  localparam int TW = btsu_pkg::TASK_W;
  localparam int GW = btsu_pkg::GI_W;
  localparam int CW = btsu_pkg::GCNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DL_CHK, S_TK_RD, S_TK_CMP, S_GC_FIND, S_GT_RD, S_GT_CMP,
    S_DR_RD, S_DR_CLR, S_DR_END, S_DONE
  } state_t;

  typedef enum logic [1:0] {RET_ACC, RET_GC, RET_GT} ret_t;

  state_t st_r;
  ret_t   ret_r;
  btsu_pkg::req_t req_r;
  logic [TW-1:0] tix_r;
  logic [btsu_pkg::LIST_W-1:0] lid_r;
  logic [btsu_pkg::GID_W-1:0]  gid_r;
  logic [btsu_pkg::TIME_W-1:0] tv_r;

  logic [NT-1:0] ready_r, dlb_r, gdb_r;
  logic          run_p_r;
  logic [TW-1:0] run_id_r;
  logic [NT-1:0] lm_r [btsu_pkg::NUM_WAIT_LISTS];
  logic [NT-1:0] gw_r [btsu_pkg::NUM_GUARD_WORDS];
  logic [btsu_pkg::LIST_W-1:0] link_r [NT];
  logic [NT-1:0] lv_r, rc_r, hdg_r;
  logic [1:0]    gs_r   [NT];
  logic [CW-1:0] gcnt_r [NT];

  logic [TW-1:0] walk_r, dtask_r;
  logic [CW-1:0] didx_r;
  logic          flag_r, err_r;
  logic          out_valid_r;
  logic [47:0]   out_data_r;

  // RAM ports
  logic                        dl_we;
  logic [btsu_pkg::TIME_W-1:0] dl_q;
  logic [TW-1:0]               dl_raddr;
  logic                        gi_we;
  logic [TW+GW-1:0]            gi_waddr, gi_raddr;
  logic [btsu_pkg::GID_W-1:0]  gi_q;

  logic          need_run, nr_err;
  logic [NT-1:0] rbit, sel_bits, wbit;
  logic [TW-1:0] sel_t, sig_t, gc_t;

  assign rbit = NT'(1) << run_id_r;
  assign wbit = NT'(1) << walk_r;
  assign need_run = (req_r == btsu_pkg::REQ_TERMINATE) || (req_r == btsu_pkg::REQ_BLK_LIST) ||
                    (req_r == btsu_pkg::REQ_BLK_DL) || (req_r == btsu_pkg::REQ_BLK_BOTH) ||
                    (req_r == btsu_pkg::REQ_REG_GUARD) || (req_r == btsu_pkg::REQ_GUARD_DL) ||
                    (req_r == btsu_pkg::REQ_WAIT) || (req_r == btsu_pkg::REQ_ACCEPT);
  assign nr_err   = need_run && !run_p_r;
  assign sel_bits = ready_r | (run_p_r ? rbit : '0);
  assign sel_t    = btsu_pkg::low_bit(sel_bits);
  assign sig_t    = btsu_pkg::low_bit(lm_r[lid_r]);
  assign gc_t     = btsu_pkg::low_bit(gw_r[gid_r]);

  always_comb begin
    dl_we = 1'b0;
    if (st_r == S_EXEC && !nr_err &&
        (req_r == btsu_pkg::REQ_BLK_DL || req_r == btsu_pkg::REQ_BLK_BOTH)) dl_we = 1'b1;
    if (st_r == S_DL_CHK && (!gdb_r[run_id_r] || dl_q > tv_r)) dl_we = 1'b1;
  end
  assign dl_raddr = (st_r == S_EXEC) ? run_id_r : walk_r;

  assign gi_we = (st_r == S_EXEC) && !nr_err && (req_r == btsu_pkg::REQ_REG_GUARD) &&
                 (gs_r[run_id_r] == btsu_pkg::GS_EVAL) &&
                 (gcnt_r[run_id_r] < CW'(btsu_pkg::GUARDS_PER_TASK));
  assign gi_waddr = {run_id_r, gcnt_r[run_id_r][GW-1:0]};
  assign gi_raddr = {dtask_r, didx_r[GW-1:0]};

  btsu_ram #(.DEPTH(NT), .WIDTH(btsu_pkg::TIME_W)) u_dl_ram (
    .clk(clk), .we(dl_we), .waddr(run_id_r), .wdata(tv_r),
    .raddr(dl_raddr), .rdata(dl_q)
  );

  btsu_ram #(.DEPTH(NT * btsu_pkg::GUARDS_PER_TASK), .WIDTH(btsu_pkg::GID_W)) u_gi_ram (
    .clk(clk), .we(gi_we), .waddr(gi_waddr), .wdata(gid_r),
    .raddr(gi_raddr), .rdata(gi_q)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ret_r       <= RET_ACC;
      ready_r     <= '0;
      dlb_r       <= '0;
      gdb_r       <= '0;
      run_p_r     <= 1'b0;
      run_id_r    <= '0;
      lv_r        <= '0;
      rc_r        <= '0;
      hdg_r       <= '0;
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
      err_r       <= 1'b0;
      walk_r      <= '0;
      dtask_r     <= '0;
      didx_r      <= '0;
      for (int i = 0; i < btsu_pkg::NUM_WAIT_LISTS; i++) lm_r[i] <= '0;
      for (int i = 0; i < btsu_pkg::NUM_GUARD_WORDS; i++) gw_r[i] <= '0;
      for (int i = 0; i < NT; i++) begin
        link_r[i] <= '0;
        gs_r[i]   <= btsu_pkg::GS_EVAL;
        gcnt_r[i] <= '0;
      end
    end else begin
      // S_DONE owns the output register while it hands over a result
      if (out_valid_r && out_tready && st_r != S_DONE) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r  <= btsu_pkg::req_t'(in_tdata[3:0]);
            tix_r  <= in_tdata[8:4];
            lid_r  <= in_tdata[12:9];
            gid_r  <= in_tdata[16:13];
            tv_r   <= in_tdata[48:17];
            flag_r <= 1'b0;
            err_r  <= 1'b0;
            st_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (nr_err) begin
            err_r <= 1'b1;
            st_r  <= S_DONE;
          end else begin
            unique case (req_r)
              btsu_pkg::REQ_CREATE: begin
                lv_r[tix_r]   <= 1'b0;
                link_r[tix_r] <= '0;
                gcnt_r[tix_r] <= '0;
                gs_r[tix_r]   <= btsu_pkg::GS_EVAL;
                ready_r[tix_r] <= 1'b1;
                st_r <= S_DONE;
              end
              btsu_pkg::REQ_SELECT: begin
                if (sel_bits != '0) begin
                  ready_r  <= sel_bits & ~(NT'(1) << sel_t);
                  run_p_r  <= 1'b1;
                  run_id_r <= sel_t;
                end else begin
                  ready_r  <= sel_bits;
                  run_p_r  <= 1'b0;
                  run_id_r <= '0;
                end
                st_r <= S_DONE;
              end
              btsu_pkg::REQ_TERMINATE: begin
                run_p_r  <= 1'b0;
                run_id_r <= '0;
                st_r     <= S_DONE;
              end
              btsu_pkg::REQ_BLK_LIST, btsu_pkg::REQ_BLK_DL, btsu_pkg::REQ_BLK_BOTH: begin
                if (req_r != btsu_pkg::REQ_BLK_DL) begin
                  lm_r[lid_r]      <= lm_r[lid_r] | rbit;
                  link_r[run_id_r] <= lid_r;
                  lv_r[run_id_r]   <= 1'b1;
                end
                if (req_r != btsu_pkg::REQ_BLK_LIST) dlb_r <= dlb_r | rbit;
                run_p_r  <= 1'b0;
                run_id_r <= '0;
                st_r     <= S_DONE;
              end
              btsu_pkg::REQ_SIGNAL: begin
                if (lm_r[lid_r] != '0) begin
                  flag_r        <= 1'b1;
                  dlb_r[sig_t]  <= 1'b0;
                  lm_r[lid_r][sig_t] <= 1'b0;
                  lv_r[sig_t]   <= 1'b0;
                  link_r[sig_t] <= '0;
                  rc_r[sig_t]   <= 1'b1;
                  ready_r[sig_t] <= 1'b1;
                end
                st_r <= S_DONE;
              end
              btsu_pkg::REQ_TICK: begin
                walk_r <= '0;
                st_r   <= S_TK_RD;
              end
              btsu_pkg::REQ_REG_GUARD: begin
                if (gs_r[run_id_r] == btsu_pkg::GS_EVAL) begin
                  if (gcnt_r[run_id_r] >= CW'(btsu_pkg::GUARDS_PER_TASK)) begin
                    err_r <= 1'b1;
                  end else begin
                    gw_r[gid_r]      <= gw_r[gid_r] | rbit;
                    gcnt_r[run_id_r] <= gcnt_r[run_id_r] + CW'(1);
                  end
                end
                st_r <= S_DONE;
              end
              btsu_pkg::REQ_GUARD_DL: begin
                st_r <= (gs_r[run_id_r] == btsu_pkg::GS_EVAL) ? S_DL_CHK : S_DONE;
              end
              btsu_pkg::REQ_WAIT: begin
                if (gs_r[run_id_r] == btsu_pkg::GS_CHANGED) begin
                  flag_r <= 1'b1;
                  gs_r[run_id_r] <= btsu_pkg::GS_EVAL;
                end else if (hdg_r[run_id_r] || gcnt_r[run_id_r] != '0) begin
                  flag_r <= 1'b1;
                  gs_r[run_id_r] <= btsu_pkg::GS_WAITING;
                  run_p_r  <= 1'b0;
                  run_id_r <= '0;
                end
                st_r <= S_DONE;
              end
              btsu_pkg::REQ_ACCEPT: begin
                gs_r[run_id_r] <= btsu_pkg::GS_EVAL;
                dtask_r <= run_id_r;
                didx_r  <= '0;
                ret_r   <= RET_ACC;
                st_r    <= S_DR_RD;
              end
              btsu_pkg::REQ_GCHANGED: st_r <= S_GC_FIND;
              btsu_pkg::REQ_GTICK: begin
                walk_r <= '0;
                st_r   <= S_GT_RD;
              end
              default: st_r <= S_DONE;
            endcase
          end
        end
        S_DL_CHK: begin
          hdg_r[run_id_r] <= 1'b1;
          gdb_r <= gdb_r | rbit;
          st_r  <= S_DONE;
        end
        S_TK_RD: st_r <= S_TK_CMP;
        S_TK_CMP: begin
          if (dlb_r[walk_r] && tv_r >= dl_q) begin
            dlb_r[walk_r] <= 1'b0;
            if (lv_r[walk_r]) begin
              lm_r[link_r[walk_r]] <= lm_r[link_r[walk_r]] & ~wbit;
              lv_r[walk_r]   <= 1'b0;
              link_r[walk_r] <= '0;
            end
            rc_r[walk_r]    <= 1'b0;
            ready_r[walk_r] <= 1'b1;
          end
          walk_r <= walk_r + TW'(1);
          st_r   <= (walk_r == TW'(NT - 1)) ? S_DONE : S_TK_RD;
        end
        S_GC_FIND: begin
          if (gw_r[gid_r] == '0) begin
            st_r <= S_DONE;
          end else begin
            gw_r[gid_r][gc_t] <= 1'b0;
            dtask_r <= gc_t;
            didx_r  <= '0;
            ret_r   <= RET_GC;
            st_r    <= S_DR_RD;
          end
        end
        S_GT_RD: st_r <= S_GT_CMP;
        S_GT_CMP: begin
          if (gdb_r[walk_r] && tv_r >= dl_q) begin
            dtask_r <= walk_r;
            didx_r  <= '0;
            ret_r   <= RET_GT;
            st_r    <= S_DR_RD;
          end else begin
            walk_r <= walk_r + TW'(1);
            st_r   <= (walk_r == TW'(NT - 1)) ? S_DONE : S_GT_RD;
          end
        end
        S_DR_RD: st_r <= (didx_r < gcnt_r[dtask_r]) ? S_DR_CLR : S_DR_END;
        S_DR_CLR: begin
          gw_r[gi_q][dtask_r] <= 1'b0;
          didx_r <= didx_r + CW'(1);
          st_r   <= S_DR_RD;
        end
        S_DR_END: begin
          gcnt_r[dtask_r] <= '0;
          gdb_r[dtask_r]  <= 1'b0;
          hdg_r[dtask_r]  <= 1'b0;
          if (ret_r != RET_ACC) begin
            if (gs_r[dtask_r] == btsu_pkg::GS_WAITING) begin
              gs_r[dtask_r]    <= btsu_pkg::GS_EVAL;
              rc_r[dtask_r]    <= 1'b1;
              ready_r[dtask_r] <= 1'b1;
            end else if (gs_r[dtask_r] == btsu_pkg::GS_EVAL) begin
              gs_r[dtask_r] <= btsu_pkg::GS_CHANGED;
            end
          end
          unique case (ret_r)
            RET_ACC: st_r <= S_DONE;
            RET_GC:  st_r <= S_GC_FIND;
            RET_GT: begin
              walk_r <= walk_r + TW'(1);
              st_r   <= (walk_r == TW'(NT - 1)) ? S_DONE : S_GT_RD;
            end
            default: st_r <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {7'd0, ready_r, err_r, flag_r, run_p_r & rc_r[run_id_r],
                            run_p_r ? run_id_r : TW'(0), run_p_r};
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // no running task means the running index reads as zero
  a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
    !run_p_r |-> run_id_r == '0) else $error("running id set with no running task");
  // a stalled result stays put until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result changed while stalled");
  // guard count of the running task stays within capacity
  a_gcnt: assert property (@(posedge clk) disable iff (!rst_n)
    gcnt_r[run_id_r] <= CW'(btsu_pkg::GUARDS_PER_TASK)) else $error("guard count overflow");
  // a finished request with a free output slot presents its result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && !out_valid_r) |=> out_valid_r) else $error("result not issued");
endmodule
`default_nettype wire

@@ hdl/btsu_ram.sv @@
// Simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module btsu_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
